// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checking off while reset is high
`define LEDBC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checking off while reset is high
`define LEDBC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define LEDBC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ledbc_pkg.sv -----
// types and constants of the indicator led blink controller
// no dependencies
package ledbc_pkg;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_STEADY_ON  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEADY_OFF = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LINK       = 2'd2;

   localparam logic [7:0] LED_HOST_MASK  = 8'hFE;
   localparam logic [7:0] LED_BOOT       = 8'h01;
   localparam logic [7:0] LED_SENT_RESET = 8'hFF;

   typedef struct packed {
      logic [7:0]  host_leds;
      logic        boot_done;
      logic        kbd_mounted;
      logic        flash_start;
      logic [15:0] flash_on_ms;
      logic [15:0] flash_off_ms;
      logic [7:0]  flash_count;
   } req_word_type;

   typedef struct packed {
      logic [7:0] led_bits;
      logic       board_led;
      logic       send_now;
   } rsp_word_type;

   // state that does not depend on the timer width
   typedef struct packed {
      logic [7:0] led_now;
      logic [7:0] last_sent;
      logic       booted;
      logic [7:0] blinks_left;
      logic       flash_phase_on;
   } ctl_state_type;

endpackage

// ----- hdl/ledbc_if.sv -----
// valid/ready channel interfaces for request and response words
// depends on ledbc_pkg
interface ledbc_req_if import ledbc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface ledbc_rsp_if import ledbc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/ledbc_step.sv -----
// one millisecond tick of the blink controller: next state and response word
// depends on ledbc_pkg
module ledbc_step import ledbc_pkg::*; #(
   parameter int TIME_BITS = 16
) (
   input  req_word_type         word,
   input  logic [15:0]          steady_on_ms,
   input  logic [15:0]          steady_off_ms,
   input  logic                 link_present,
   input  ctl_state_type        ctl_cur,
   input  logic [TIME_BITS-1:0] steady_left_cur,
   input  logic [TIME_BITS-1:0] flash_left_cur,
   input  logic [TIME_BITS-1:0] flash_on_len_cur,
   input  logic [TIME_BITS-1:0] flash_off_len_cur,
   output ctl_state_type        ctl_nxt,
   output logic [TIME_BITS-1:0] steady_left_nxt,
   output logic [TIME_BITS-1:0] flash_left_nxt,
   output logic [TIME_BITS-1:0] flash_on_len_nxt,
   output logic [TIME_BITS-1:0] flash_off_len_nxt,
   output rsp_word_type         rsp
);

   logic [TIME_BITS-1:0] st_on;
   logic [TIME_BITS-1:0] st_off;
   logic                 led_bit;
   logic                 blink_done;

   assign st_on  = TIME_BITS'(steady_on_ms);
   assign st_off = TIME_BITS'(steady_off_ms);

   always_comb begin
      ctl_nxt           = ctl_cur;
      flash_on_len_nxt  = flash_on_len_cur;
      flash_off_len_nxt = flash_off_len_cur;
      led_bit           = 1'b0;
      blink_done        = 1'b0;
      rsp.board_led     = 1'b1;
      rsp.send_now      = 1'b0;

      // countdowns saturate at zero
      steady_left_nxt = (steady_left_cur == '0) ? '0 : steady_left_cur - 1'b1;
      flash_left_nxt  = (flash_left_cur == '0) ? '0 : flash_left_cur - 1'b1;

      ctl_nxt.booted = ctl_cur.booted | word.boot_done;

      if (word.flash_start) begin
         if (word.flash_count == 8'd0) begin
            ctl_nxt.blinks_left = 8'd0;
         end else begin
            flash_on_len_nxt       = TIME_BITS'(word.flash_on_ms);
            flash_off_len_nxt      = TIME_BITS'(word.flash_off_ms);
            ctl_nxt.blinks_left    = word.flash_count;
            ctl_nxt.flash_phase_on = 1'b1;
            flash_left_nxt         = TIME_BITS'(word.flash_on_ms);
         end
      end

      if (!ctl_nxt.booted) begin
         ctl_nxt.led_now = LED_BOOT;
         if ((LED_BOOT != ctl_cur.last_sent) && link_present) begin
            ctl_nxt.last_sent = LED_BOOT;
            rsp.send_now      = 1'b1;
         end
      end else if (word.kbd_mounted) begin
         // one-shot pattern first
         if (ctl_nxt.blinks_left != 8'd0) begin
            if (flash_left_nxt == '0) begin
               if (ctl_nxt.flash_phase_on) begin
                  ctl_nxt.flash_phase_on = 1'b0;
                  flash_left_nxt         = flash_off_len_nxt;
               end else begin
                  ctl_nxt.blinks_left = ctl_nxt.blinks_left - 8'd1;
                  if (ctl_nxt.blinks_left != 8'd0) begin
                     ctl_nxt.flash_phase_on = 1'b1;
                     flash_left_nxt         = flash_on_len_nxt;
                  end
               end
            end
            if (ctl_nxt.blinks_left != 8'd0) begin
               led_bit    = ctl_nxt.flash_phase_on;
               blink_done = 1'b1;
            end else begin
               // pattern over: steady blink toggles at once
               steady_left_nxt = '0;
            end
         end
         if (!blink_done) begin
            if ((steady_on_ms == 16'd0) && (steady_off_ms == 16'd0)) begin
               led_bit = 1'b0;
            end else if (steady_left_nxt == '0) begin
               led_bit         = ~ctl_cur.led_now[0];
               steady_left_nxt = led_bit ? st_on : st_off;
            end else begin
               led_bit = ctl_cur.led_now[0];
            end
         end
         ctl_nxt.led_now = (word.host_leds & LED_HOST_MASK) | {7'd0, led_bit};
         rsp.board_led   = led_bit;
         if ((ctl_nxt.led_now != ctl_cur.last_sent) && link_present) begin
            ctl_nxt.last_sent = ctl_nxt.led_now;
            rsp.send_now      = 1'b1;
         end
      end

      rsp.led_bits = ctl_nxt.led_now;
   end

endmodule

// ----- hdl/indicator_led_blink_controller.sv -----
// Path: a word taken on req_ch goes into the input register, then the response register,
// from which it is offered on rsp_ch; one word per cycle sustained while rsp_ch is not stalled.
// The tick state feeds back through the combinational step, so words may arrive back to back.
// Reset (synchronous, active high) empties both registers, clears the csr
// registers and the blink state, and sets the last sent value to 0xFF.
// Top level of the indicator led blink controller; depends on ledbc_pkg, ledbc_if, ledbc_step
module indicator_led_blink_controller import ledbc_pkg::*; #(
   parameter int TIME_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   ledbc_req_if.sink                req_ch,
   ledbc_rsp_if.source              rsp_ch,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic [15:0]          steady_on_ff;
   logic [15:0]          steady_off_ff;
   logic                 link_ff;

   logic                 stage_valid_ff;
   req_word_type         stage_ff;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_ff;

   ctl_state_type        ctl_ff;
   ctl_state_type        ctl_in;
   logic [TIME_BITS-1:0] steady_left_ff;
   logic [TIME_BITS-1:0] steady_left_in;
   logic [TIME_BITS-1:0] flash_left_ff;
   logic [TIME_BITS-1:0] flash_left_in;
   logic [TIME_BITS-1:0] flash_on_len_ff;
   logic [TIME_BITS-1:0] flash_on_len_in;
   logic [TIME_BITS-1:0] flash_off_len_ff;
   logic [TIME_BITS-1:0] flash_off_len_in;
   rsp_word_type         rsp_in;

   logic                 advance;
   logic                 req_take;

   // staged word moves on when the response register is free or being drained
   assign advance  = stage_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_take = req_ch.valid & req_ch.ready;

   assign req_ch.ready = ~stage_valid_ff | advance;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steady_on_ff  <= '0;
         steady_off_ff <= '0;
         link_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEADY_ON:  steady_on_ff  <= csr_wdata;
            CSR_STEADY_OFF: steady_off_ff <= csr_wdata;
            CSR_LINK:       link_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ledbc_step #(
      .TIME_BITS(TIME_BITS)
   ) u_step (
      .word              (stage_ff),
      .steady_on_ms      (steady_on_ff),
      .steady_off_ms     (steady_off_ff),
      .link_present      (link_ff),
      .ctl_cur           (ctl_ff),
      .steady_left_cur   (steady_left_ff),
      .flash_left_cur    (flash_left_ff),
      .flash_on_len_cur  (flash_on_len_ff),
      .flash_off_len_cur (flash_off_len_ff),
      .ctl_nxt           (ctl_in),
      .steady_left_nxt   (steady_left_in),
      .flash_left_nxt    (flash_left_in),
      .flash_on_len_nxt  (flash_on_len_in),
      .flash_off_len_nxt (flash_off_len_in),
      .rsp               (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            stage_valid_ff <= req_take;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= req_ch.data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.led_now        <= '0;
         ctl_ff.last_sent      <= LED_SENT_RESET;
         ctl_ff.booted         <= 1'b0;
         ctl_ff.blinks_left    <= '0;
         ctl_ff.flash_phase_on <= 1'b0;
         steady_left_ff        <= '0;
         flash_left_ff         <= '0;
         flash_on_len_ff       <= '0;
         flash_off_len_ff      <= '0;
      end else if (advance) begin
         ctl_ff           <= ctl_in;
         steady_left_ff   <= steady_left_in;
         flash_left_ff    <= flash_left_in;
         flash_on_len_ff  <= flash_on_len_in;
         flash_off_len_ff <= flash_off_len_in;
      end
   end

endmodule

// ----- hdl/ledbc_checker.sv -----
// port-level checks on the blink controller, bound to the top level
// depends on ledbc_pkg and assert_macros.svh
`include "assert_macros.svh"

module ledbc_checker import ledbc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   // a stalled response word stays put
   `LEDBC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response word changed while stalled")

   // reset leaves no response pending
   `LEDBC_ASSERT_NXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid, "response valid just after reset")

   // an empty response register never blocks intake
   `LEDBC_ASSERT_NOW(a_req_open, clock, reset, !rsp_valid, req_ready, "request blocked with empty response register")

   // a dark board lamp only ever mirrors a dark indicator bit
   `LEDBC_ASSERT_NOW(a_board_dark, clock, reset, rsp_valid && !rsp_data.board_led, !rsp_data.led_bits[0], "board lamp dark while indicator bit lit")

endmodule

bind indicator_led_blink_controller ledbc_checker u_ledbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for the indicator led blink controller: directed ticks, then random
// phases under several csr settings, checked against an in-bench tick model
// depends on ledbc_pkg, ledbc_if and indicator_led_blink_controller
module tb_top;
   import ledbc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 175;
   localparam int MAX_REPORTS = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_STEADY_ON;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   ledbc_req_if req_ch();
   ledbc_rsp_if rsp_ch();

   indicator_led_blink_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // tick model state
   logic [7:0]  lamp_byte      = 8'h00;
   logic [7:0]  sent_byte      = LED_SENT_RESET;
   logic        booted         = 1'b0;
   logic [15:0] steady_cnt     = '0;
   logic [7:0]  blinks_left    = '0;
   logic        flash_on_phase = 1'b0;
   logic [15:0] flash_cnt      = '0;
   logic [15:0] flash_on_len   = '0;
   logic [15:0] flash_off_len  = '0;
   logic [15:0] cfg_steady_on  = '0;
   logic [15:0] cfg_steady_off = '0;
   logic        cfg_link       = 1'b0;

   req_word_type tick_pending_q[$];
   rsp_word_type led_expect_q[$];
   int words_queued = 0;
   int words_taken  = 0;
   int mismatch_cnt = 0;
   int cycle_cnt    = 0;
   logic word_taken = 1'b0;
   logic kbd_level  = 1'b1;

   function automatic rsp_word_type next_led_word(req_word_type w);
      rsp_word_type r;
      logic ind;
      logic pattern_live;
      r = '0;
      if (steady_cnt != 0) steady_cnt = steady_cnt - 1'b1;
      if (flash_cnt != 0) flash_cnt = flash_cnt - 1'b1;
      if (w.boot_done) booted = 1'b1;
      if (w.flash_start) begin
         if (w.flash_count == 0) begin
            blinks_left = '0;
         end else begin
            flash_on_len   = w.flash_on_ms;
            flash_off_len  = w.flash_off_ms;
            blinks_left    = w.flash_count;
            flash_on_phase = 1'b1;
            flash_cnt      = w.flash_on_ms;
         end
      end
      if (!booted) begin
         lamp_byte   = LED_BOOT;
         r.board_led = 1'b1;
         if (lamp_byte != sent_byte && cfg_link) begin
            sent_byte  = lamp_byte;
            r.send_now = 1'b1;
         end
      end else if (!w.kbd_mounted) begin
         r.board_led = 1'b1;
      end else begin
         ind = 1'b0;
         pattern_live = 1'b0;
         if (blinks_left != 0) begin
            if (flash_cnt == 0) begin
               if (flash_on_phase) begin
                  flash_on_phase = 1'b0;
                  flash_cnt      = flash_off_len;
               end else begin
                  blinks_left = blinks_left - 1'b1;
                  if (blinks_left != 0) begin
                     flash_on_phase = 1'b1;
                     flash_cnt      = flash_on_len;
                  end
               end
            end
            // pattern over: steady blink restarts at once
            if (blinks_left != 0) begin
               ind = flash_on_phase;
               pattern_live = 1'b1;
            end else begin
               steady_cnt = '0;
            end
         end
         if (!pattern_live) begin
            if (cfg_steady_on == 0 && cfg_steady_off == 0) begin
               ind = 1'b0;
            end else if (steady_cnt == 0) begin
               ind = ~lamp_byte[0];
               steady_cnt = ind ? cfg_steady_on : cfg_steady_off;
            end else begin
               ind = lamp_byte[0];
            end
         end
         lamp_byte   = (w.host_leds & LED_HOST_MASK) | {7'b0, ind};
         r.board_led = lamp_byte[0];
         if (lamp_byte != sent_byte && cfg_link) begin
            sent_byte  = lamp_byte;
            r.send_now = 1'b1;
         end
      end
      r.led_bits = lamp_byte;
      return r;
   endfunction

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         mismatch_cnt++;
         if (mismatch_cnt <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      end
   endtask

   // monitor: model runs on each accepted tick, responses checked in order
   always @(posedge clock) begin : monitor
      rsp_word_type exp_w;
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else if (reset) begin
         word_taken <= 1'b0;
      end else begin
         word_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            led_expect_q.push_back(next_led_word(req_ch.data));
            words_taken++;
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            if (led_expect_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= MAX_REPORTS)
                  $error("rsp word 0x%0h with no tick waiting", rsp_ch.data);
            end else begin
               exp_w = led_expect_q.pop_front();
               check_field("led_bits", int'(exp_w.led_bits), int'(rsp_ch.data.led_bits));
               check_field("board_led", int'(exp_w.board_led), int'(rsp_ch.data.board_led));
               check_field("send_now", int'(exp_w.send_now), int'(rsp_ch.data.send_now));
            end
         end
      end
   end

   // sender: bursts of ticks with random gaps in between
   int gap_left   = 0;
   int burst_left = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(negedge clock) begin : driver
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || word_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (tick_pending_q.size() != 0) begin
            req_ch.data  <= tick_pending_q.pop_front();
            req_ch.valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left--;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: stall style is redrawn at random from three modes, paced by rx_cycle
   int rx_cycle   = 0;
   int stall_mode = 0;
   int stall_left = 0;

   always @(negedge clock) begin : receiver
      rx_cycle++;
      if (rx_cycle % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (stall_left != 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_mode == 1) begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end else if (stall_mode == 2 && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 8);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic queue_tick(req_word_type w);
      tick_pending_q.push_back(w);
      words_queued++;
   endtask

   task automatic tick(logic [7:0] host, logic boot, logic kbd, logic fs,
                       logic [15:0] on_ms, logic [15:0] off_ms, logic [7:0] cnt);
      req_word_type w;
      w.host_leds    = host;
      w.boot_done    = boot;
      w.kbd_mounted  = kbd;
      w.flash_start  = fs;
      w.flash_on_ms  = on_ms;
      w.flash_off_ms = off_ms;
      w.flash_count  = cnt;
      queue_tick(w);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (words_taken != words_queued || led_expect_q.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_STEADY_ON:  cfg_steady_on  = value;
         CSR_STEADY_OFF: cfg_steady_off = value;
         CSR_LINK:       cfg_link       = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_word_type random_tick();
      req_word_type w;
      int pick;
      w.host_leds    = 8'($urandom_range(0, 255));
      w.boot_done    = ($urandom_range(0, 7) == 0);
      w.flash_on_ms  = 16'($urandom_range(0, 65535));
      w.flash_off_ms = 16'($urandom_range(0, 65535));
      w.flash_count  = 8'($urandom_range(0, 255));
      // keyboard drops out now and then for a short stretch
      if (kbd_level) kbd_level = ($urandom_range(0, 99) >= 2);
      else kbd_level = ($urandom_range(0, 99) < 30);
      w.kbd_mounted = kbd_level;
      w.flash_start = ($urandom_range(0, 99) < 4);
      if (w.flash_start) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            w.flash_on_ms  = 16'($urandom_range(0, 5));
            w.flash_off_ms = 16'($urandom_range(0, 5));
            w.flash_count  = 8'($urandom_range(1, 3));
         end else if (pick == 7) begin
            w.flash_count = 8'd0;
         end else if (w.flash_count == 0) begin
            w.flash_count = 8'd1;
         end
      end
      return w;
   endfunction

   logic [15:0] phase_on [8] = '{16'd5, 16'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd2};
   logic [15:0] phase_off[8] = '{16'd3, 16'd0, 16'hFFFF, 16'd4, 16'd0, 16'd0, 16'd0, 16'd2};
   logic        phase_lnk[8] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

   initial begin : stimulus
      logic [15:0] on_v;
      logic [15:0] off_v;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // before boot, link absent, csr still at reset values
      tick(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00);
      tick(8'hFF, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
      tick(8'hAA, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000, 8'h00);
      tick(8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00);
      tick(8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      wait_idle();
      write_reg(CSR_STEADY_ON, 16'd3);
      write_reg(CSR_STEADY_OFF, 16'd1);
      // lamp turns on with host 0xFF: merged 0xFF equals the reset sent value
      tick(8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      wait_idle();
      write_reg(CSR_LINK, 16'd1);
      tick(8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      tick(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      tick(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      // zero-length on phase
      tick(8'h10, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0002, 8'h02);
      for (int i = 0; i < 6; i++)
         tick(8'h80 >> i, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      tick(8'h7E, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
      tick(8'h01, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      tick(8'hFE, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      // cancel with junk lengths
      tick(8'h42, 1'b0, 1'b1, 1'b1, 16'hA5A5, 16'h5A5A, 8'h00);
      tick(8'h3C, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00);
      tick(8'hC3, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 8'h00);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         on_v  = phase_on[p];
         off_v = phase_off[p];
         if (p == 5) begin
            on_v  = 16'($urandom_range(0, 30));
            off_v = 16'($urandom_range(0, 30));
         end
         write_reg(CSR_STEADY_ON, on_v);
         write_reg(CSR_STEADY_OFF, off_v);
         write_reg(CSR_LINK, {15'b0, phase_lnk[p]});
         for (int i = 0; i < PHASE_WORDS; i++)
            queue_tick(random_tick());
         wait_idle();
      end

      repeat (8) @(negedge clock);
      if (mismatch_cnt == 0 && led_expect_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ledbc_pkg.sv
hdl/ledbc_if.sv
hdl/ledbc_step.sv
hdl/indicator_led_blink_controller.sv
hdl/ledbc_checker.sv
tb/tb_top.sv
